// ===== design/sad_fitness_ranker_top_macros.svh =====
// Assertion macros shared by the ranker top level.
`ifndef SAD_FITNESS_RANKER_TOP_MACROS_SVH
`define SAD_FITNESS_RANKER_TOP_MACROS_SVH

// Implication in the same cycle, sampled on clk, quiet while arst_n is low.
`define SADR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle, sampled on clk, quiet while arst_n is low.
`define SADR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sadr_pkg.sv =====
// Shared widths and the result struct of the SAD fitness ranker.
package sadr_pkg;

	localparam int PIX_W       = 8;
	localparam int DIST_W      = 22;
	localparam int IDX_FIELD_W = 6;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef struct packed {
		logic                   valid;
		logic [IDX_FIELD_W-1:0] idx;
		logic [DIST_W-1:0]      distance;
		logic                   last;
	} result_t;

endpackage

// ===== design/sad_fitness_ranker_top.sv =====
// SAD fitness ranker: per-row sum of absolute differences, then ranked read-out.
//
// Pixel-pair requests stream in one per cycle while a set loads: each request
// adds |target - candidate| to a running row sum that clamps at 4194303. A
// request with tuser (last_of_row) or tlast (last_of_set) high closes the row
// and, for the first POPULATION rows of the set, stores its distance under the
// row's arrival number; later rows are summed and dropped. A request with
// tlast high starts ranking: tready falls and the block emits one result per
// stored row, in ascending distance with ties to the lower arrival number, and
// raises m_axis_tlast on the last one. Ranking runs a selection scan through
// the distance store, which has a single read port: each result takes a read
// of every stored row, a compare flush and an emit, which waits while the
// output side stalls. tready rises again in the cycle after the last result
// is handed to the output register, so a new set may load while that result
// still waits to be taken.
module sad_fitness_ranker_top #(
	parameter int POPULATION = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] target_pixel, [15:8] candidate_pixel
	input  logic        s_axis_tuser,   // [0] last_of_row
	input  logic        s_axis_tlast,   // last_of_set
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [5:0] candidate_index, [27:6] distance, [31:28] zero
	output logic        m_axis_tlast    // final_rank
);

	`include "sad_fitness_ranker_top_macros.svh"

	localparam int IDX_W = $clog2(POPULATION);
	localparam int CNT_W = $clog2(POPULATION+1);

	logic                        s_accept;
	logic                        row_close;
	logic                        row_store;
	logic [sadr_pkg::DIST_W-1:0] row_sum;
	logic [CNT_W-1:0]            rows_loaded_q;
	logic [CNT_W-1:0]            rows_next;
	logic                        rank_busy;
	logic                        out_ready;
	sadr_pkg::result_t           res;

	logic                             m_valid_q;
	logic [sadr_pkg::IDX_FIELD_W-1:0] m_idx_q;
	logic [sadr_pkg::DIST_W-1:0]      m_dist_q;
	logic                             m_last_q;

	// Take pixel requests whenever no ranking run is under way.
	assign s_axis_tready = !rank_busy;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign row_close     = s_axis_tuser || s_axis_tlast;
	// Rows past the population are dropped; their sum is simply cleared.
	assign row_store     = s_accept && row_close && (rows_loaded_q < CNT_W'(POPULATION));
	assign rows_next     = row_store ? CNT_W'(rows_loaded_q + 1'b1) : rows_loaded_q;

	// The output register may be refilled when empty or when it drains this cycle.
	assign out_ready = !m_valid_q || m_axis_tready;

	sadr_accum u_accum (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (s_accept),
		.clr             (row_close),
		.target_pixel    (s_axis_tdata[7:0]),
		.candidate_pixel (s_axis_tdata[15:8]),
		.sum             (row_sum)
	);

	sadr_ranker #(
		.POPULATION (POPULATION)
	) u_ranker (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (row_store),
		.wr_addr     (rows_loaded_q[IDX_W-1:0]),
		.wr_data     (row_sum),
		.start       (s_accept && s_axis_tlast),
		.start_count (rows_next),
		.out_ready   (out_ready),
		.busy        (rank_busy),
		.res         (res)
	);

	// Count stored rows; a set end hands the count to the ranker and restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_loaded_q <= '0;
		end else if (s_accept) begin
			rows_loaded_q <= s_axis_tlast ? '0 : rows_next;
		end
	end

	// Output register: hold a result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_idx_q  <= res.idx;
			m_dist_q <= res.distance;
			m_last_q <= res.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0000, m_dist_q, m_idx_q};
	assign m_axis_tlast  = m_last_q;

	// A new result never lands on one that is still waiting.
	`SADR_ASSERT_NOW(a_no_overwrite, res.valid, out_ready, "result overwrote a pending result")
	// A set end always starts a ranking run.
	`SADR_ASSERT_NEXT(a_set_starts_rank, s_accept && s_axis_tlast, rank_busy, "set end did not start ranking")
	// The final result closes the run and reopens the input.
	`SADR_ASSERT_NEXT(a_last_ends_rank, res.valid && res.last, !rank_busy && m_axis_tlast, "ranking did not end on final result")
	// The stored-row count never passes the population.
	`SADR_ASSERT_NOW(a_rows_bounded, 1'b1, rows_loaded_q <= CNT_W'(POPULATION), "row count exceeded population")

endmodule

// ===== design/sadr_accum.sv =====
// Row accumulator: absolute pixel difference added to a saturating running sum.
module sadr_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          clr,
	input  logic [sadr_pkg::PIX_W-1:0]    target_pixel,
	input  logic [sadr_pkg::PIX_W-1:0]    candidate_pixel,
	output logic [sadr_pkg::DIST_W-1:0]   sum
);

	logic [sadr_pkg::DIST_W-1:0] running_sum_q;
	logic [sadr_pkg::PIX_W-1:0]  diff;
	logic [sadr_pkg::DIST_W:0]   wide_sum;

	always_comb begin
		diff = (target_pixel > candidate_pixel) ? (target_pixel - candidate_pixel)
		                                        : (candidate_pixel - target_pixel);
		wide_sum = {1'b0, running_sum_q} + (sadr_pkg::DIST_W+1)'(diff);
		// carry out means the sum passed the all-ones maximum: clamp
		sum = wide_sum[sadr_pkg::DIST_W] ? sadr_pkg::DIST_MAX
		                                 : wide_sum[sadr_pkg::DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
		end else if (en) begin
			running_sum_q <= clr ? '0 : sum;
		end
	end

endmodule

// ===== design/sadr_ranker.sv =====
// Distance store and selection-scan sequencer that emits rows in rank order.
module sadr_ranker #(
	parameter int POPULATION = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [$clog2(POPULATION)-1:0] wr_addr,
	input  logic [sadr_pkg::DIST_W-1:0] wr_data,
	input  logic                        start,
	input  logic [$clog2(POPULATION+1)-1:0] start_count,
	input  logic                        out_ready,
	output logic                        busy,
	output sadr_pkg::result_t           res
);

	localparam int IDX_W = $clog2(POPULATION);
	localparam int CNT_W = $clog2(POPULATION+1);
	localparam int IdxFw = sadr_pkg::IDX_FIELD_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                  state_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            rank_q;
	logic [CNT_W-1:0]            addr_q;
	logic                        rd_vld_s1;
	logic [IDX_W-1:0]            rd_idx_s1;
	logic [sadr_pkg::DIST_W-1:0] rd_dist_s1;
	logic                        have_prev_q;
	logic [sadr_pkg::DIST_W-1:0] prev_dist_q;
	logic [IDX_W-1:0]            prev_idx_q;
	logic                        best_vld_q;
	logic [sadr_pkg::DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]            best_idx_q;

	logic [sadr_pkg::DIST_W-1:0] mem [POPULATION];

	logic issue;
	logic eligible;
	logic take;
	logic is_last;

	always_comb begin
		issue = (state_q == ST_SCAN) && (addr_q < count_q);
		// key compare: (dist, index) strictly after the last emitted key
		eligible = !have_prev_q || (rd_dist_s1 > prev_dist_q) ||
		           ((rd_dist_s1 == prev_dist_q) && (rd_idx_s1 > prev_idx_q));
		// indices rise through the scan, so equal distance keeps the earlier one
		take = rd_vld_s1 && eligible && (!best_vld_q || (rd_dist_s1 < best_dist_q));
		is_last = (CNT_W'(rank_q + 1'b1) == count_q);
		busy = (state_q != ST_IDLE);
		res.valid    = (state_q == ST_EMIT) && out_ready;
		res.idx      = IdxFw'(best_idx_q);
		res.distance = best_dist_q;
		res.last     = is_last;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_dist_s1 <= mem[addr_q[IDX_W-1:0]];
		rd_idx_s1  <= addr_q[IDX_W-1:0];
		if (take) begin
			best_dist_q <= rd_dist_s1;
			best_idx_q  <= rd_idx_s1;
		end
		if (res.valid) begin
			prev_dist_q <= best_dist_q;
			prev_idx_q  <= best_idx_q;
		end
		if (start) begin
			count_q <= start_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rank_q      <= '0;
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			have_prev_q <= 1'b0;
			best_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (take) begin
				best_vld_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q     <= ST_SCAN;
						rank_q      <= '0;
						addr_q      <= '0;
						have_prev_q <= 1'b0;
						best_vld_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						addr_q <= CNT_W'(addr_q + 1'b1);
					end else if (rd_vld_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						have_prev_q <= 1'b1;
						best_vld_q  <= 1'b0;
						rank_q      <= CNT_W'(rank_q + 1'b1);
						addr_q      <= '0;
						state_q     <= is_last ? ST_IDLE : ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
